FILE: hw/rtl/range_assign_add_min_tree_top_macros.svh
// Assertion macros shared by the range assign/add/min tree RTL.
// Included by ratm_store and range_assign_add_min_tree_top; no other dependencies.
`ifndef RANGE_ASSIGN_ADD_MIN_TREE_TOP_MACROS_SVH
`define RANGE_ASSIGN_ADD_MIN_TREE_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RATM_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Implication checked from one edge to the same edge.
`define RATM_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ratm_pkg.sv
// Shared types, constants and saturating arithmetic for the range assign/add/min tree.
// No dependencies; used by ratm_store and range_assign_add_min_tree_top.
package ratm_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int VALUE_BITS = 48;
    localparam int SPAN_W     = 11;

    function automatic int pad_pow2(input int n);
        int p;
        p = 1;
        for (int i = 0; i < 17; i++) begin
            if (p < n) p = p * 2;
        end
        return p;
    endfunction

    localparam int PADDED     = pad_pow2(LEAF_COUNT);
    localparam int NODE_COUNT = 2 * PADDED - 1;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int BOUND_W    = $clog2(PADDED + 1);
    localparam int STK_DEPTH  = $clog2(PADDED);
    localparam int SP_W       = $clog2(STK_DEPTH + 1);
    localparam int IX_W       = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;

    localparam logic [1:0] FUNC_ASSIGN = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [ADDR_W-1:0]            t_addr;
    typedef logic [BOUND_W-1:0]           t_bound;

    localparam t_value VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam t_value VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef struct packed {
        logic   pend;
        t_value asg;
        t_value add;
        t_value mn;
    } t_node;

    localparam t_node NODE_RESET = '{pend: 1'b0, asg: '0, add: '0, mn: VMAX};

    typedef struct packed {
        logic  re;
        t_addr raddr;
        logic  we;
        t_addr waddr;
        t_node wdata;
    } t_mem_req;

    typedef struct packed {
        t_bound     s;
        t_bound     t;
        t_bound     l;
        t_bound     r;
        t_addr      id;
        logic [1:0] phase;
        t_value     vl;
    } t_frame;

    function automatic t_value sat_add(input t_value a, input t_value b);
        logic signed [VALUE_BITS:0] sum;
        sum = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (sum[VALUE_BITS] != sum[VALUE_BITS-1]) begin
            return sum[VALUE_BITS] ? VMIN : VMAX;
        end
        return sum[VALUE_BITS-1:0];
    endfunction

    function automatic t_value min_val(input t_value a, input t_value b);
        return (a < b) ? a : b;
    endfunction

endpackage

FILE: hw/rtl/range_assign_add_min_tree_top.sv
// Top level of the range assign/add/min lazy tree: walk sequencer and frame stack.
// Depends on ratm_pkg, ratm_store and the macro header.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------------------------
//   command   | start, busy        | i_func, i_range_start, i_range_end, i_operand_value
//   result    | o_strobe (1 cycle) | o_span_minimum
//
// After reset all 2047 nodes of the node memory are cleared while busy is high.
// A fully covered node on the walk is read once and, for assign or add, written once;
// a split node costs three reads and three writes of the single node memory, and
// assign and add repeat that push for each split node on the way back up. An empty
// or unused command leaves busy low.
// One command is in flight at a time; results cannot be stalled.
`include "range_assign_add_min_tree_top_macros.svh"

module range_assign_add_min_tree_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_func,
    input  logic [ratm_pkg::SPAN_W-1:0] i_range_start,
    input  logic [ratm_pkg::SPAN_W-1:0] i_range_end,
    input  ratm_pkg::t_value          i_operand_value,
    output logic                      o_strobe,
    output ratm_pkg::t_value          o_span_minimum
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_NODE   = 3'd2;
    localparam logic [2:0] S_LEAF   = 3'd3;
    localparam logic [2:0] S_PUSH   = 3'd4;
    localparam logic [2:0] S_RETURN = 3'd5;

    localparam logic [1:0] PH_ENTER = 2'd0;
    localparam logic [1:0] PH_CALL  = 2'd1;
    localparam logic [1:0] PH_RETL  = 2'd2;
    localparam logic [1:0] PH_RETR  = 2'd3;

    logic [2:0]             r_state;
    logic [2:0]             r_mc;
    logic                   r_fin;
    logic [1:0]             r_op;
    ratm_pkg::t_value       r_x;
    ratm_pkg::t_value       r_ret;
    ratm_pkg::t_frame       r_cur;
    ratm_pkg::t_frame       r_stk [ratm_pkg::STK_DEPTH];
    logic [ratm_pkg::SP_W-1:0] r_sp;
    ratm_pkg::t_node        r_nid, r_nlc, r_nrc;
    ratm_pkg::t_value       r_v, r_sl, r_sr;
    logic                   r_strobe;
    ratm_pkg::t_value       r_min_out;

    ratm_pkg::t_mem_req     mem_req;
    ratm_pkg::t_node        mem_rdata;
    logic                   mem_ready;

    ratm_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_ready (mem_ready)
    );

    function automatic ratm_pkg::t_bound clamp(input logic [ratm_pkg::SPAN_W-1:0] v);
        if (32'(v) > ratm_pkg::LEAF_COUNT) return ratm_pkg::BOUND_W'(ratm_pkg::LEAF_COUNT);
        return ratm_pkg::BOUND_W'(v);
    endfunction

    ratm_pkg::t_bound     in_s, in_t, mid;
    logic [ratm_pkg::BOUND_W:0] mid_sum;
    logic                 full_cover;
    ratm_pkg::t_addr      lc_id, rc_id;
    ratm_pkg::t_frame     child_l, child_r, push_frame;
    ratm_pkg::t_node      leaf_node, pend_node;
    logic [ratm_pkg::IX_W-1:0] sp_ix, sp_m1;
    logic [ratm_pkg::SP_W-1:0] sp_dec;

    assign in_s       = clamp(i_range_start);
    assign in_t       = clamp(i_range_end);
    assign mid_sum    = {1'b0, r_cur.l} + {1'b0, r_cur.r};
    assign mid        = mid_sum[ratm_pkg::BOUND_W:1];
    assign full_cover = (r_cur.s == r_cur.l) && (r_cur.t == r_cur.r);
    assign lc_id      = {r_cur.id[ratm_pkg::ADDR_W-2:0], 1'b1};
    assign rc_id      = lc_id + 1'b1;
    assign sp_dec     = r_sp - 1'b1;
    assign sp_ix      = r_sp[ratm_pkg::IX_W-1:0];
    assign sp_m1      = sp_dec[ratm_pkg::IX_W-1:0];
    assign pend_node  = '{pend: 1'b1, asg: r_v, add: '0, mn: r_v};

    always_comb begin
        child_l       = r_cur;
        child_l.t     = (mid < r_cur.t) ? mid : r_cur.t;
        child_l.r     = mid;
        child_l.id    = lc_id;
        child_l.phase = PH_ENTER;
        child_l.vl    = ratm_pkg::VMAX;
        child_r       = r_cur;
        child_r.s     = (r_cur.s < mid) ? mid : r_cur.s;
        child_r.l     = mid;
        child_r.id    = rc_id;
        child_r.phase = PH_ENTER;
        child_r.vl    = ratm_pkg::VMAX;
    end

    // Frame saved before descending: it records which child comes back next, and
    // after the left child it carries that child's minimum.
    always_comb begin
        push_frame    = r_cur;
        push_frame.vl = ratm_pkg::VMAX;
        if (r_cur.phase == PH_RETL) begin
            push_frame.phase = PH_RETR;
            push_frame.vl    = r_ret;
        end else if (r_cur.s < mid) begin
            push_frame.phase = PH_RETL;
        end else begin
            push_frame.phase = PH_RETR;
        end
    end

    always_comb begin
        leaf_node = mem_rdata;
        leaf_node.add = ratm_pkg::sat_add(mem_rdata.add, r_x);
        if (r_op == ratm_pkg::FUNC_ASSIGN) begin
            leaf_node = '{pend: 1'b1, asg: r_x, add: '0, mn: r_x};
        end
    end

    always_comb begin
        mem_req = '0;
        unique case (r_state)
            S_LEAF: begin
                if (r_mc == 3'd0) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_cur.id;
                end else if (r_op != ratm_pkg::FUNC_QUERY) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_cur.id;
                    mem_req.wdata = leaf_node;
                end
            end
            S_PUSH: begin
                unique case (r_mc)
                    3'd0: begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = r_cur.id;
                    end
                    3'd1: begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = lc_id;
                    end
                    3'd2: begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = rc_id;
                    end
                    3'd5: begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = lc_id;
                        mem_req.wdata = r_nid.pend ? pend_node : r_nlc;
                    end
                    3'd6: begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = rc_id;
                        mem_req.wdata = r_nid.pend ? pend_node : r_nrc;
                    end
                    3'd7: begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = r_cur.id;
                        if (r_nid.pend) begin
                            mem_req.wdata = '{pend: 1'b0, asg: '0, add: '0, mn: r_v};
                        end else begin
                            mem_req.wdata = '{pend: r_nid.pend, asg: r_nid.asg, add: '0,
                                              mn: ratm_pkg::min_val(r_sl, r_sr)};
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_sp     <= '0;
            r_mc     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (mem_ready) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_op  <= i_func;
                        r_x   <= i_operand_value;
                        r_sp  <= '0;
                        r_cur <= '{s: in_s, t: in_t, l: '0,
                                   r: ratm_pkg::BOUND_W'(ratm_pkg::PADDED),
                                   id: '0, phase: PH_ENTER, vl: ratm_pkg::VMAX};
                        if (i_func == ratm_pkg::FUNC_ASSIGN || i_func == ratm_pkg::FUNC_ADD ||
                            i_func == ratm_pkg::FUNC_QUERY) begin
                            if (in_s < in_t) begin
                                r_state <= S_NODE;
                            end else if (i_func == ratm_pkg::FUNC_QUERY) begin
                                // An empty query answers at once with the sentinel.
                                r_strobe  <= 1'b1;
                                r_min_out <= ratm_pkg::VMAX;
                            end
                        end
                    end
                end
                S_NODE: begin
                    unique case (r_cur.phase)
                        PH_ENTER: begin
                            r_mc    <= '0;
                            r_fin   <= 1'b0;
                            r_state <= full_cover ? S_LEAF : S_PUSH;
                        end
                        PH_CALL: begin
                            r_stk[sp_ix] <= push_frame;
                            r_sp         <= r_sp + 1'b1;
                            if (r_cur.s < mid) begin
                                r_cur <= child_l;
                            end else begin
                                r_cur <= child_r;
                            end
                        end
                        PH_RETL: begin
                            if (mid < r_cur.t) begin
                                r_stk[sp_ix] <= push_frame;
                                r_sp         <= r_sp + 1'b1;
                                r_cur        <= child_r;
                            end else if (r_op == ratm_pkg::FUNC_QUERY) begin
                                r_state <= S_RETURN;
                            end else begin
                                r_mc    <= '0;
                                r_fin   <= 1'b1;
                                r_state <= S_PUSH;
                            end
                        end
                        PH_RETR: begin
                            r_ret <= ratm_pkg::min_val(r_cur.vl, r_ret);
                            if (r_op == ratm_pkg::FUNC_QUERY) begin
                                r_state <= S_RETURN;
                            end else begin
                                // The pull-up is a second push: the node's tags are clear now.
                                r_mc    <= '0;
                                r_fin   <= 1'b1;
                                r_state <= S_PUSH;
                            end
                        end
                        default: ;
                    endcase
                end
                S_LEAF: begin
                    if (r_mc == 3'd0) begin
                        r_mc <= 3'd1;
                    end else begin
                        r_ret   <= ratm_pkg::sat_add(mem_rdata.mn, mem_rdata.add);
                        r_state <= S_RETURN;
                    end
                end
                S_PUSH: begin
                    r_mc <= r_mc + 1'b1;
                    unique case (r_mc)
                        3'd1: r_nid <= mem_rdata;
                        3'd2: r_nlc <= mem_rdata;
                        3'd3: r_nrc <= mem_rdata;
                        3'd4: begin
                            r_v       <= ratm_pkg::sat_add(r_nid.asg, r_nid.add);
                            r_nlc.add <= ratm_pkg::sat_add(r_nlc.add, r_nid.add);
                            r_nrc.add <= ratm_pkg::sat_add(r_nrc.add, r_nid.add);
                        end
                        3'd5: begin
                            r_sl <= ratm_pkg::sat_add(r_nlc.mn, r_nlc.add);
                            r_sr <= ratm_pkg::sat_add(r_nrc.mn, r_nrc.add);
                        end
                        3'd7: begin
                            if (r_fin) begin
                                r_state <= S_RETURN;
                            end else begin
                                r_cur.phase <= PH_CALL;
                                r_state     <= S_NODE;
                            end
                        end
                        default: ;
                    endcase
                end
                S_RETURN: begin
                    if (r_sp == '0) begin
                        if (r_op == ratm_pkg::FUNC_QUERY) begin
                            r_strobe  <= 1'b1;
                            r_min_out <= r_ret;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_cur   <= r_stk[sp_m1];
                        r_sp    <= sp_dec;
                        r_state <= S_NODE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_span_minimum = r_min_out;

    `RATM_IMPLY(a_strobe_query, o_strobe, r_op == ratm_pkg::FUNC_QUERY, "result for non-query")
    `RATM_CHECK(a_sp_bound, r_sp <= ratm_pkg::SP_W'(ratm_pkg::STK_DEPTH), "stack overflow")
    `RATM_CHECK(a_rw_excl, !(mem_req.re && mem_req.we), "read and write in one cycle")
    `RATM_IMPLY(a_strobe_done, o_strobe, r_state == S_IDLE, "result while walking")

endmodule

FILE: hw/rtl/ratm_store.sv
// Node memory of the lazy tree: one write and one registered read port per cycle,
// plus the clearing sweep after reset. Depends on ratm_pkg and the macro header.
`include "range_assign_add_min_tree_top_macros.svh"

module ratm_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ratm_pkg::t_mem_req i_req,
    output ratm_pkg::t_node   o_rdata,
    output logic              o_ready
);

    ratm_pkg::t_node r_mem [ratm_pkg::NODE_COUNT];
    ratm_pkg::t_node r_rdata;
    logic            r_clearing;
    ratm_pkg::t_addr r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ratm_pkg::ADDR_W'(ratm_pkg::NODE_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= ratm_pkg::NODE_RESET;
        end else if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;

    `RATM_IMPLY(a_clear_quiet, r_clearing, !i_req.we && !i_req.re, "access during clear")
    `RATM_IMPLY(a_clear_full, $fell(r_clearing),
        $past(r_clr_addr) == ratm_pkg::ADDR_W'(ratm_pkg::NODE_COUNT - 1), "short clear")
    `RATM_CHECK(a_no_same_addr, !(i_req.we && i_req.re && i_req.waddr == i_req.raddr),
        "read and write of one node in one cycle")

endmodule

FILE: sim/range_assign_add_min_tree_top_test.sv
// Self-checking testbench for the range assign/add/min lazy tree.
// Depends on ratm_pkg and range_assign_add_min_tree_top; an in-bench lazy tree predicts queries.
module range_assign_add_min_tree_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LEAF_COUNT  = ratm_pkg::LEAF_COUNT;
    localparam int         VALUE_BITS  = ratm_pkg::VALUE_BITS;
    localparam int         SPAN_W      = ratm_pkg::SPAN_W;
    localparam logic [1:0] FUNC_ASSIGN = ratm_pkg::FUNC_ASSIGN;
    localparam logic [1:0] FUNC_ADD    = ratm_pkg::FUNC_ADD;
    localparam logic [1:0] FUNC_QUERY  = ratm_pkg::FUNC_QUERY;

    typedef ratm_pkg::t_value t_value;

    localparam t_value VMAX = ratm_pkg::VMAX;
    localparam t_value VMIN = ratm_pkg::VMIN;

    localparam int  TREE_NODES = 2 * LEAF_COUNT - 1;
    localparam longint VAL_HI = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    localparam longint VAL_LO = -VAL_HI - 1;

    typedef struct {
        logic [1:0]        func;
        logic [SPAN_W-1:0] lo;
        logic [SPAN_W-1:0] hi;
        t_value            operand;
    } t_range_cmd;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_func;
    logic [SPAN_W-1:0] i_range_start;
    logic [SPAN_W-1:0] i_range_end;
    t_value            i_operand_value;
    logic              o_strobe;
    t_value            o_span_minimum;

    range_assign_add_min_tree_top dut (.*);

    t_range_cmd cmd_queue[$];
    longint     expected_minimums[$];
    int         mismatch_count = 0;
    int         gap_left = 0;
    bit         quiet_phase = 0;
    bit         cmd_taken = 0;

    // Predictor copy of the lazy tree.
    bit     node_pending[TREE_NODES];
    longint node_assign[TREE_NODES];
    longint node_add[TREE_NODES];
    longint node_min[TREE_NODES];

    function automatic longint clamp_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > VAL_HI) return VAL_HI;
        if (s < VAL_LO) return VAL_LO;
        return s;
    endfunction

    function automatic longint lesser(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic void tree_clear();
        for (int i = 0; i < TREE_NODES; i++) begin
            node_pending[i] = 0;
            node_assign[i] = 0;
            node_add[i] = 0;
            node_min[i] = VAL_HI;
        end
    endfunction

    function automatic void refresh_min(int id);
        node_min[id] = lesser(clamp_sum(node_min[2*id+1], node_add[2*id+1]),
                              clamp_sum(node_min[2*id+2], node_add[2*id+2]));
    endfunction

    function automatic void fill_node(int id, longint v);
        node_pending[id] = 1;
        node_assign[id] = v;
        node_add[id] = 0;
        node_min[id] = v;
    endfunction

    // Moves a node's lazy tags into its children.
    function automatic void push_tags(int id);
        longint v;
        if (id >= LEAF_COUNT - 1) return;
        if (node_pending[id]) begin
            v = clamp_sum(node_assign[id], node_add[id]);
            fill_node(2*id+1, v);
            fill_node(2*id+2, v);
            node_pending[id] = 0;
            node_assign[id] = 0;
            node_add[id] = 0;
            node_min[id] = v;
        end else begin
            node_add[2*id+1] = clamp_sum(node_add[2*id+1], node_add[id]);
            node_add[2*id+2] = clamp_sum(node_add[2*id+2], node_add[id]);
            node_add[id] = 0;
            refresh_min(id);
        end
    endfunction

    function automatic void update_span(int s, int t, int l, int r, int id,
                                        longint x, bit is_assign);
        int m;
        if (s == l && t == r) begin
            if (is_assign) fill_node(id, x);
            else node_add[id] = clamp_sum(node_add[id], x);
            return;
        end
        push_tags(id);
        m = (l + r) / 2;
        if (s < m && m < t) begin
            update_span(s, m, l, m, 2*id+1, x, is_assign);
            update_span(m, t, m, r, 2*id+2, x, is_assign);
        end else if (s < m) begin
            update_span(s, t, l, m, 2*id+1, x, is_assign);
        end else if (m < t) begin
            update_span(s, t, m, r, 2*id+2, x, is_assign);
        end
        refresh_min(id);
    endfunction

    function automatic longint span_min(int s, int t, int l, int r, int id);
        longint v;
        int m;
        v = 0;
        if (s == l && t == r) begin
            v = node_min[id];
        end else begin
            push_tags(id);
            m = (l + r) / 2;
            if (s < m && m < t) v = lesser(span_min(s, m, l, m, 2*id+1),
                                           span_min(m, t, m, r, 2*id+2));
            else if (s < m) v = span_min(s, t, l, m, 2*id+1);
            else if (m < t) v = span_min(s, t, m, r, 2*id+2);
        end
        return clamp_sum(v, node_add[id]);
    endfunction

    // Applies one accepted command; queries leave their minimum in the expected store.
    function automatic void apply_command(t_range_cmd c);
        int s;
        int t;
        s = (c.lo > LEAF_COUNT) ? LEAF_COUNT : int'(c.lo);
        t = (c.hi > LEAF_COUNT) ? LEAF_COUNT : int'(c.hi);
        if (c.func == FUNC_ASSIGN || c.func == FUNC_ADD) begin
            if (s < t) update_span(s, t, 0, LEAF_COUNT, 0, longint'(c.operand),
                                   c.func == FUNC_ASSIGN);
        end else if (c.func == FUNC_QUERY) begin
            expected_minimums.push_back((s < t) ? span_min(s, t, 0, LEAF_COUNT, 0) : VAL_HI);
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic add_cmd(logic [1:0] f, int lo, int hi, t_value v);
        t_range_cmd c;
        c.func = f;
        c.lo = lo[SPAN_W-1:0];
        c.hi = hi[SPAN_W-1:0];
        c.operand = v;
        cmd_queue.push_back(c);
    endtask

    function automatic t_value random_operand();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return VMAX;
        if (sel == 1) return VMIN;
        if (sel < 5) return t_value'($signed($urandom_range(0, 2000)) - 1000);
        return t_value'({$urandom, $urandom});
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Driver: a command stays on the ports until its transfer, then the next one follows.
    always @(negedge i_clk) begin
        t_range_cmd c;
        bit drive;
        if (start && cmd_taken) void'(cmd_queue.pop_front());
        drive = 0;
        if (i_rst_n && cmd_queue.size() > 0) begin
            if (start && !cmd_taken) begin
                drive = 1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 16);
            end else begin
                drive = 1;
            end
        end
        if (drive) begin
            c = cmd_queue[0];
            i_func <= c.func;
            i_range_start <= c.lo;
            i_range_end <= c.hi;
            i_operand_value <= c.operand;
        end
        start <= drive;
    end

    // Monitor: checks results first, then predicts for the command taken at this edge.
    always @(posedge i_clk) begin
        t_range_cmd c;
        longint got;
        cmd_taken = i_rst_n && start && !busy;
        if (i_rst_n && o_strobe) begin
            got = longint'(o_span_minimum);
            if (expected_minimums.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", got));
            end else begin
                if (got != expected_minimums[0])
                    report_mismatch($sformatf("span minimum %0d, expected %0d",
                                              got, expected_minimums[0]));
                void'(expected_minimums.pop_front());
            end
        end
        if (cmd_taken) begin
            c.func = i_func;
            c.lo = i_range_start;
            c.hi = i_range_end;
            c.operand = i_operand_value;
            apply_command(c);
        end
    end

    initial begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int f;
        int lo;
        int hi;
        int w;
        tree_clear();
        i_rst_n = 0;
        start = 0;
        i_func = FUNC_QUERY;
        i_range_start = '0;
        i_range_end = '0;
        i_operand_value = '0;

        // Directed: untouched sentinel, extremes, empty and clamped spans, the unused code.
        add_cmd(FUNC_QUERY, 0, 1024, 0);
        add_cmd(FUNC_ADD, 3, 9, VMAX);
        add_cmd(FUNC_ADD, 5, 7, VMIN);
        add_cmd(FUNC_QUERY, 0, 16, 0);
        add_cmd(FUNC_ASSIGN, 0, 1024, 0);
        add_cmd(FUNC_ASSIGN, 0, 1, VMIN);
        add_cmd(FUNC_ADD, 0, 2, VMIN);
        add_cmd(FUNC_QUERY, 0, 1, 0);
        add_cmd(FUNC_ASSIGN, 1023, 2047, VMAX);
        add_cmd(FUNC_ADD, 1000, 2047, VMAX);
        add_cmd(FUNC_QUERY, 1023, 2047, 0);
        add_cmd(FUNC_QUERY, 2047, 2047, 0);
        add_cmd(FUNC_ASSIGN, 500, 400, 77);
        add_cmd(FUNC_ADD, 9, 9, 5);
        add_cmd(FUNC_QUERY, 600, 500, 0);
        add_cmd(2'd3, 0, 1024, VMIN);
        add_cmd(FUNC_ADD, 1, 1023, -3);
        add_cmd(FUNC_QUERY, 1, 1023, 0);
        add_cmd(FUNC_QUERY, 0, 1024, 0);
        add_cmd(FUNC_ASSIGN, 1024, 2047, 1);
        add_cmd(FUNC_QUERY, 511, 513, 0);

        for (int i = 0; i < 1750; i++) begin
            w = $urandom_range(0, 99);
            f = (w < 30) ? FUNC_ASSIGN : (w < 60) ? FUNC_ADD : (w < 97) ? FUNC_QUERY : 3;
            w = $urandom_range(0, 19);
            if (w == 0) begin
                lo = $urandom_range(0, 2047);
                hi = $urandom_range(0, 2047);
            end else if (w < 6) begin
                lo = $urandom_range(0, 1023);
                hi = lo + $urandom_range(1, 4);
            end else begin
                lo = $urandom_range(0, 1023);
                hi = $urandom_range(lo, 1024);
            end
            add_cmd(f[1:0], lo, hi, random_operand());
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        while (cmd_queue.size() >= 150) @(posedge i_clk);
        quiet_phase = 1;
        while (cmd_queue.size() != 0 || expected_minimums.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        #1;
        if (mismatch_count == 0 && expected_minimums.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
